// ===== rtl/core/pft_pkg.sv =====
`default_nettype none

package pft_pkg;

    // per-datagram phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_FIELD   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_VERDICT = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    // header field identifiers
    typedef enum logic [3:0] {
        FID_SEQ    = 4'd0,
        FID_FINDEX = 4'd1,
        FID_FCOUNT = 4'd2,
        FID_FEC    = 4'd3,
        FID_ADDR   = 4'd4,
        FID_PLEN   = 4'd5,
        FID_RSK    = 4'd6,
        FID_RSZ    = 4'd7,
        FID_SOURCE = 4'd8,
        FID_DEST   = 4'd9
    } fid_t;

    // datagram status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SYNC  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_CRC_FAIL  = 3'd4
    } status_t;

    // sync bytes and fixed header positions
    localparam logic [7:0]  SYNC_P       = 8'h50;
    localparam logic [7:0]  SYNC_F       = 8'h46;
    localparam logic [4:0]  POS_SYNC_P   = 5'd0;
    localparam logic [4:0]  POS_SYNC_F   = 5'd1;
    localparam logic [4:0]  POS_SEQ      = 5'd3;
    localparam logic [4:0]  POS_FINDEX   = 5'd6;
    localparam logic [4:0]  POS_FCOUNT   = 5'd9;
    localparam logic [4:0]  POS_FLAGS    = 5'd10;
    localparam logic [4:0]  POS_PLEN     = 5'd11;
    localparam logic [4:0]  POS_OPT      = 5'd12;
    localparam logic [4:0]  POS_RSZ      = 5'd13;
    localparam logic [4:0]  HDR_MIN      = 5'd14;
    localparam logic [4:0]  FEC_EXTRA    = 5'd2;
    localparam logic [4:0]  ADDR_EXTRA   = 5'd4;
    localparam logic [14:0] COUNT_MAX    = 15'h7FFF;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    // per-datagram parser state
    typedef struct packed {
        phase_t       phase;
        logic [4:0]   hdr_pos;
        logic [23:0]  shift;
        logic         fec;
        logic         addr;
        logic [13:0]  plen;
        logic [15:0]  crc;
        logic [13:0]  pcount;
        logic [14:0]  consumed;
        status_t      err;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:    PH_HEADER,
        hdr_pos:  5'd0,
        shift:    24'd0,
        fec:      1'b0,
        addr:     1'b0,
        plen:     14'd0,
        crc:      CRC_INIT,
        pcount:   14'd0,
        consumed: 15'd0,
        err:      ST_OK
    };

    // one result item
    typedef struct packed {
        kind_t        kind;
        fid_t         field_id;
        logic [23:0]  value;
        status_t      status;
        logic         end_of_run;
    } result_t;

    function automatic result_t make_res(input kind_t k, input fid_t f,
                                         input logic [23:0] v, input status_t s);
        result_t r;
        r.kind       = k;
        r.field_id   = f;
        r.value      = v;
        r.status     = s;
        r.end_of_run = 1'b0;
        return r;
    endfunction

    // ccitt crc over one byte, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pft_parse_step.sv =====
`default_nettype none

module pft_parse_step (
    input  wire pft_pkg::state_t  cur,
    input  wire [7:0]             data_byte,
    input  wire                   end_of_datagram,
    input  wire                   crc_always,
    output pft_pkg::state_t       nxt,
    output pft_pkg::result_t      res0,
    output pft_pkg::result_t      res1,
    output logic [1:0]            num
);

    logic [4:0]            hlen;
    logic [4:0]            abase;
    logic [4:0]            p;
    logic                  check;
    logic                  good;
    logic                  ok;
    pft_pkg::status_t      done_st;
    logic [23:0]           done_val;
    pft_pkg::result_t      done_res;

    assign p     = cur.hdr_pos;
    assign hlen  = pft_pkg::HDR_MIN
                 + (cur.fec  ? pft_pkg::FEC_EXTRA  : 5'd0)
                 + (cur.addr ? pft_pkg::ADDR_EXTRA : 5'd0);
    assign abase = pft_pkg::POS_OPT + (cur.fec ? pft_pkg::FEC_EXTRA : 5'd0);

    // one byte through the header / payload parser
    always_comb
    begin
        nxt      = cur;
        res0     = '0;
        res1     = '0;
        num      = 2'd0;
        check    = 1'b0;
        good     = 1'b0;
        ok       = 1'b0;
        done_st  = pft_pkg::ST_OK;
        done_val = 24'd0;
        done_res = '0;

        // saturating byte count
        if (cur.consumed != pft_pkg::COUNT_MAX)
            nxt.consumed = cur.consumed + 15'd1;

        case (cur.phase)
            pft_pkg::PH_HEADER:
            begin
                nxt.shift = {cur.shift[15:0], data_byte};
                if (({1'b0, p} + 6'd2) < {1'b0, hlen})
                    nxt.crc = pft_pkg::crc_feed(cur.crc, data_byte);

                if (p == pft_pkg::POS_SYNC_P && data_byte != pft_pkg::SYNC_P)
                begin
                    nxt.phase = pft_pkg::PH_DISCARD;
                    nxt.err   = pft_pkg::ST_BAD_SYNC;
                end
                else if (p == pft_pkg::POS_SYNC_F && data_byte != pft_pkg::SYNC_F)
                begin
                    nxt.phase = pft_pkg::PH_DISCARD;
                    nxt.err   = pft_pkg::ST_BAD_SYNC;
                end
                else if (p == pft_pkg::POS_SEQ)
                begin
                    res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_SEQ,
                                             {8'h00, nxt.shift[15:0]}, pft_pkg::ST_OK);
                    num  = 2'd1;
                end
                else if (p == pft_pkg::POS_FINDEX)
                begin
                    res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_FINDEX,
                                             nxt.shift, pft_pkg::ST_OK);
                    num  = 2'd1;
                end
                else if (p == pft_pkg::POS_FCOUNT)
                begin
                    res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_FCOUNT,
                                             nxt.shift, pft_pkg::ST_OK);
                    num  = 2'd1;
                end
                else if (p == pft_pkg::POS_FLAGS)
                begin
                    nxt.fec  = data_byte[7];
                    nxt.addr = data_byte[6];
                    res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_FEC,
                                             {23'd0, data_byte[7]}, pft_pkg::ST_OK);
                    res1 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_ADDR,
                                             {23'd0, data_byte[6]}, pft_pkg::ST_OK);
                    num  = 2'd2;
                end
                else if (p == pft_pkg::POS_PLEN)
                begin
                    nxt.plen = nxt.shift[13:0];
                    res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_PLEN,
                                             {10'd0, nxt.shift[13:0]}, pft_pkg::ST_OK);
                    num  = 2'd1;
                end
                else if (p >= pft_pkg::POS_OPT)
                begin
                    if (cur.fec && p == pft_pkg::POS_OPT)
                    begin
                        res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_RSK,
                                                 {16'd0, data_byte}, pft_pkg::ST_OK);
                        num  = 2'd1;
                    end
                    else if (cur.fec && p == pft_pkg::POS_RSZ)
                    begin
                        res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_RSZ,
                                                 {16'd0, data_byte}, pft_pkg::ST_OK);
                        num  = 2'd1;
                    end
                    else if (cur.addr && p == abase + 5'd1)
                    begin
                        res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_SOURCE,
                                                 {8'h00, nxt.shift[15:0]}, pft_pkg::ST_OK);
                        num  = 2'd1;
                    end
                    else if (cur.addr && p == abase + 5'd3)
                    begin
                        res0 = pft_pkg::make_res(pft_pkg::KIND_FIELD, pft_pkg::FID_DEST,
                                                 {8'h00, nxt.shift[15:0]}, pft_pkg::ST_OK);
                        num  = 2'd1;
                    end
                    else if (({1'b0, p} + 6'd1) == {1'b0, hlen})
                    begin
                        // last header byte: crc verdict
                        check = cur.fec | crc_always;
                        good  = (nxt.shift[15:0] == ~cur.crc);
                        ok    = !check || good;
                        nxt.err    = ok ? pft_pkg::ST_OK : pft_pkg::ST_CRC_FAIL;
                        nxt.phase  = pft_pkg::PH_PAYLOAD;
                        nxt.pcount = 14'd0;
                        res0 = pft_pkg::make_res(pft_pkg::KIND_VERDICT, pft_pkg::FID_SEQ,
                                                 {23'd0, ok},
                                                 ok ? pft_pkg::ST_OK : pft_pkg::ST_CRC_FAIL);
                        num  = 2'd1;
                    end
                end

                if (nxt.phase == pft_pkg::PH_HEADER)
                begin
                    nxt.hdr_pos = p + 5'd1;
                    // datagram ended inside the header: fields are dropped
                    if (end_of_datagram)
                        num = 2'd0;
                end
            end

            pft_pkg::PH_PAYLOAD:
            begin
                if (cur.pcount < cur.plen)
                begin
                    if (cur.err == pft_pkg::ST_OK)
                    begin
                        res0 = pft_pkg::make_res(pft_pkg::KIND_PAYLOAD, pft_pkg::FID_SEQ,
                                                 {16'd0, data_byte}, pft_pkg::ST_OK);
                        num  = 2'd1;
                    end
                    nxt.pcount = cur.pcount + 14'd1;
                end
            end

            default:
            begin
                // discard: bytes are only counted
            end
        endcase

        // end of datagram: done status and length (header plus payload if ok, header only on crc fail), then clear
        if (end_of_datagram)
        begin
            if (nxt.phase == pft_pkg::PH_DISCARD)
                done_st = ({4'd0, nxt.consumed} >= {14'd0, pft_pkg::HDR_MIN})
                        ? pft_pkg::ST_BAD_SYNC : pft_pkg::ST_SHORT;
            else if (nxt.phase == pft_pkg::PH_HEADER)
                done_st = pft_pkg::ST_SHORT;
            else if (nxt.pcount < nxt.plen)
                done_st = pft_pkg::ST_TRUNC;
            else if (nxt.err == pft_pkg::ST_CRC_FAIL)
            begin
                done_st  = pft_pkg::ST_CRC_FAIL;
                done_val = {19'd0, hlen};
            end
            else
            begin
                done_st  = pft_pkg::ST_OK;
                done_val = {19'd0, hlen} + {10'd0, nxt.plen};
            end

            done_res = pft_pkg::make_res(pft_pkg::KIND_DONE, pft_pkg::FID_SEQ,
                                         done_val, done_st);
            if (num == 2'd0)
            begin
                res0 = done_res;
                num  = 2'd1;
            end
            else
            begin
                res1 = done_res;
                num  = 2'd2;
            end
            nxt = pft_pkg::STATE_RESET;
        end

        // mark the last result of this item
        if (num == 2'd1)
            res0.end_of_run = 1'b1;
        else if (num == 2'd2)
            res1.end_of_run = 1'b1;
    end

endmodule

`default_nettype wire

// ===== rtl/core/pft_fragment_header_parser.sv =====
// an item waits in the input stage register, then its first result is registered in out_reg
// throughput: one item per cycle while out_ready is high and each item gives at most one
//   result; an item with two results holds the parse stage until its second result,
//   kept in a spare output register, has moved on to the output register
// reset: asynchronous, active low; clears all parser state and crc_always
`default_nettype none

module pft_fragment_header_parser (
    input  wire          clk,
    input  wire          rst_n,
    // configuration
    input  wire          cfg_we,
    input  wire          cfg_wdata,
    // input items
    input  wire          in_valid,
    output logic         in_ready,
    input  wire [7:0]    data_byte,
    input  wire          end_of_datagram,
    // result items
    output logic         out_valid,
    input  wire          out_ready,
    output logic [1:0]   kind,
    output logic [3:0]   field_id,
    output logic [23:0]  value,
    output logic [2:0]   status,
    output logic         end_of_run
);

    logic               crc_always_reg;
    logic               stg_valid_reg;
    logic [7:0]         stg_byte_reg;
    logic               stg_eod_reg;
    pft_pkg::state_t    state_reg;
    pft_pkg::state_t    state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    pft_pkg::result_t   out_reg;
    pft_pkg::result_t   out_next;
    logic               spare_valid_reg;
    logic               spare_valid_next;
    pft_pkg::result_t   spare_reg;
    pft_pkg::result_t   spare_next;
    pft_pkg::result_t   res0;
    pft_pkg::result_t   res1;
    logic [1:0]         num;
    logic               fire;

    // staged item is parsed when both result slots can take its output
    assign fire     = stg_valid_reg && !spare_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stg_valid_reg || fire;

    pft_parse_step u_step (
        .cur             (state_reg),
        .data_byte       (stg_byte_reg),
        .end_of_datagram (stg_eod_reg),
        .crc_always      (crc_always_reg),
        .nxt             (state_next),
        .res0            (res0),
        .res1            (res1),
        .num             (num)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_always_reg <= 1'b0;
        else if (cfg_we)
            crc_always_reg <= cfg_wdata;
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            stg_valid_reg <= 1'b1;
        else if (fire)
            stg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_byte_reg <= data_byte;
            stg_eod_reg  <= end_of_datagram;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pft_pkg::STATE_RESET;
        else if (fire)
            state_reg <= state_next;
    end

    // result slots: output register plus spare for a second result
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        spare_valid_next = spare_valid_reg;
        spare_next       = spare_reg;
        if (fire)
        begin
            case (num)
                2'd0:
                begin
                    out_valid_next = 1'b0;
                end
                2'd1:
                begin
                    out_valid_next = 1'b1;
                    out_next       = res0;
                end
                2'd2:
                begin
                    out_valid_next   = 1'b1;
                    out_next         = res0;
                    spare_valid_next = 1'b1;
                    spare_next       = res1;
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end
        else if (out_valid_reg && out_ready)
        begin
            if (spare_valid_reg)
            begin
                out_next         = spare_reg;
                spare_valid_next = 1'b0;
            end
            else
                out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        spare_reg <= spare_next;
    end

    // result ports
    assign out_valid  = out_valid_reg;
    assign kind       = out_reg.kind;
    assign field_id   = out_reg.field_id;
    assign value      = out_reg.value;
    assign status     = out_reg.status;
    assign end_of_run = out_reg.end_of_run;

endmodule

`default_nettype wire
